@@ design/bdp_pkg.sv @@
package bdp_pkg;

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 16;
  localparam int MAX_WORDS = 1 << ADDR_W;
  localparam int CNT_W     = ADDR_W + 1;
  localparam int LEN_W     = 6;
  localparam int FILL_W    = 5;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = 16;

  // Stream payload widths, padded to whole bytes. The function code travels in tuser.
  localparam int IN_BITS   = WORD_W + LEN_W + IDX_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = WORD_W + CNT_W + STAT_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_WORDS);

endpackage

@@ design/bdp_ram.sv @@
module bdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/balanced_digit_packer.sv @@
// Channel  | Direction | Payload
// in_*     | slave     | tuser: func[1:0]; tdata: digit[31:0], bit_len[37:32], index[53:38],
//          |           | zero pad
// out_*    | master    | tdata: out_word[31:0], word_count[48:32], status[50:49], zero pad
//
// Pushes may follow each other in every cycle while no read or finish is in progress;
// a push gives no result. A read first reads the word store, then loads the output.
// A finish stores any partial word, then loads the output; a ripple adds a fetch of word 0
// and a read-modify-write for each word the carry passes, one read-modify-write per cycle.
// Reset is synchronous, active low, with no clearing pass: reads are guarded by the count.
// A result waiting at the output does not stall pushes; reads and finishes wait for it.
module balanced_digit_packer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [bdp_pkg::IN_W-1:0] in_tdata,   // digit, bit_len, index
  input  logic [bdp_pkg::FUNC_W-1:0] in_tuser, // func
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [bdp_pkg::OUT_W-1:0] out_tdata  // out_word, word_count, status
);

  typedef enum logic [1:0] {S_IDLE, S_RIP_ISSUE, S_RIP, S_RESP} state_t;

  state_t                         state_r, state_nxt;
  logic [bdp_pkg::CNT_W-1:0]      stored_r, stored_nxt;
  logic [bdp_pkg::WORD_W-1:0]     partial_r, partial_nxt;
  logic [bdp_pkg::FILL_W-1:0]     filled_r, filled_nxt;
  logic [bdp_pkg::WORD_W-1:0]     carry_r, carry_nxt;
  logic                           finished_r, finished_nxt;
  logic [bdp_pkg::CNT_W-1:0]      rip_ptr_r, rip_ptr_nxt;
  logic                           resp_fin_r, resp_fin_nxt;
  logic [bdp_pkg::STAT_W-1:0]     resp_status_r, resp_status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [bdp_pkg::WORD_W-1:0]     out_word_r, out_word_nxt;
  logic [bdp_pkg::CNT_W-1:0]      out_count_r, out_count_nxt;
  logic [bdp_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;

  logic [bdp_pkg::FUNC_W-1:0]     in_func;
  logic [bdp_pkg::WORD_W-1:0]     in_digit;
  logic [bdp_pkg::LEN_W-1:0]      in_bit_len;
  logic [bdp_pkg::IDX_W-1:0]      in_index;
  logic                           in_xfer;

  logic                           ram_we, ram_re;
  logic [bdp_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [bdp_pkg::WORD_W-1:0]     ram_wdata, ram_rdata;

  // Push datapath
  logic [bdp_pkg::LEN_W-1:0]      len_c;
  logic [bdp_pkg::CNT_W-1:0]      base_stored;
  logic [bdp_pkg::WORD_W-1:0]     base_partial, base_carry;
  logic [bdp_pkg::FILL_W-1:0]     base_filled;
  logic signed [bdp_pkg::WORD_W:0] sum_c, shifted_c;
  logic [bdp_pkg::WORD_W-1:0]     mask_c, field_c;
  logic [2*bdp_pkg::WORD_W-1:0]   comb_c;
  logic [bdp_pkg::LEN_W-1:0]      total_c;

  // Finish and ripple datapath
  logic                           fin_store;
  logic [bdp_pkg::CNT_W-1:0]      stored_after;
  logic signed [bdp_pkg::WORD_W+1:0] rip_sum_c;
  logic [bdp_pkg::CNT_W-1:0]      rip_next;

  assign in_func    = in_tuser;
  assign in_digit   = in_tdata[31:0];
  assign in_bit_len = in_tdata[37:32];
  assign in_index   = in_tdata[53:38];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;

  always_comb begin
    if (in_bit_len == '0) begin
      len_c = bdp_pkg::LEN_W'(1);
    end else if (in_bit_len > bdp_pkg::LEN_W'(bdp_pkg::WORD_W)) begin
      len_c = bdp_pkg::LEN_W'(bdp_pkg::WORD_W);
    end else begin
      len_c = in_bit_len;
    end
  end

  // A push after finish starts a new packing from a clean state.
  assign base_stored  = finished_r ? '0 : stored_r;
  assign base_partial = finished_r ? '0 : partial_r;
  assign base_filled  = finished_r ? '0 : filled_r;
  assign base_carry   = finished_r ? '0 : carry_r;

  assign sum_c     = $signed({in_digit[bdp_pkg::WORD_W-1], in_digit})
                   + $signed({base_carry[bdp_pkg::WORD_W-1], base_carry});
  assign mask_c    = (len_c == bdp_pkg::LEN_W'(bdp_pkg::WORD_W)) ? '1
                   : ((bdp_pkg::WORD_W'(1) << len_c) - bdp_pkg::WORD_W'(1));
  assign field_c   = sum_c[bdp_pkg::WORD_W-1:0] & mask_c;
  assign shifted_c = sum_c >>> len_c;
  assign comb_c    = {{bdp_pkg::WORD_W{1'b0}}, base_partial}
                   | ({{bdp_pkg::WORD_W{1'b0}}, field_c} << base_filled);
  assign total_c   = bdp_pkg::LEN_W'(base_filled) + len_c;

  assign fin_store    = (filled_r != '0) && (stored_r < bdp_pkg::MAX_CNT);
  assign stored_after = stored_r + bdp_pkg::CNT_W'(fin_store);

  assign rip_sum_c = $signed({2'b00, ram_rdata})
                   + $signed({{2{carry_r[bdp_pkg::WORD_W-1]}}, carry_r});
  assign rip_next  = rip_ptr_r + bdp_pkg::CNT_W'(1);

  always_comb begin
    state_nxt       = state_r;
    stored_nxt      = stored_r;
    partial_nxt     = partial_r;
    filled_nxt      = filled_r;
    carry_nxt       = carry_r;
    finished_nxt    = finished_r;
    rip_ptr_nxt     = rip_ptr_r;
    resp_fin_nxt    = resp_fin_r;
    resp_status_nxt = resp_status_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_word_nxt    = out_word_r;
    out_count_nxt   = out_count_r;
    out_status_nxt  = out_status_r;
    ram_we          = 1'b0;
    ram_waddr       = base_stored[bdp_pkg::ADDR_W-1:0];
    ram_wdata       = comb_c[bdp_pkg::WORD_W-1:0];
    ram_re          = 1'b0;
    ram_raddr       = in_index[bdp_pkg::ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            bdp_pkg::FUNC_PUSH: begin
              finished_nxt = 1'b0;
              carry_nxt    = shifted_c[bdp_pkg::WORD_W-1:0];
              filled_nxt   = total_c[bdp_pkg::FILL_W-1:0];
              stored_nxt   = base_stored;
              if (total_c[bdp_pkg::FILL_W]) begin
                partial_nxt = comb_c[2*bdp_pkg::WORD_W-1:bdp_pkg::WORD_W];
                if (base_stored < bdp_pkg::MAX_CNT) begin
                  ram_we     = 1'b1;
                  stored_nxt = base_stored + bdp_pkg::CNT_W'(1);
                end
              end else begin
                partial_nxt = comb_c[bdp_pkg::WORD_W-1:0];
              end
            end
            bdp_pkg::FUNC_FINISH: begin
              resp_fin_nxt = 1'b1;
              if (!finished_r) begin
                ram_we      = fin_store;
                ram_waddr   = stored_r[bdp_pkg::ADDR_W-1:0];
                ram_wdata   = partial_r;
                stored_nxt  = stored_after;
                partial_nxt = '0;
                filled_nxt  = '0;
                rip_ptr_nxt = '0;
                if ((carry_r != '0) && (stored_after != '0)) begin
                  state_nxt = S_RIP_ISSUE;
                end else begin
                  finished_nxt = 1'b1;
                  state_nxt    = S_RESP;
                end
              end else begin
                state_nxt = S_RESP;
              end
            end
            bdp_pkg::FUNC_READ: begin
              ram_re       = 1'b1;
              resp_fin_nxt = 1'b0;
              resp_status_nxt = ({1'b0, in_index} < stored_r) ? bdp_pkg::STAT_OK
                                                               : bdp_pkg::STAT_BAD_INDEX;
              state_nxt    = S_RESP;
            end
            default: begin
            end
          endcase
        end
      end
      S_RIP_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = rip_ptr_r[bdp_pkg::ADDR_W-1:0];
        state_nxt = S_RIP;
      end
      S_RIP: begin
        // Word p is written back while word p+1 is fetched, so the two never collide.
        ram_we    = 1'b1;
        ram_waddr = rip_ptr_r[bdp_pkg::ADDR_W-1:0];
        ram_wdata = rip_sum_c[bdp_pkg::WORD_W-1:0];
        carry_nxt = {{(bdp_pkg::WORD_W-1){rip_sum_c[bdp_pkg::WORD_W+1]}},
                     rip_sum_c[bdp_pkg::WORD_W]};
        if ((rip_sum_c[bdp_pkg::WORD_W+1:bdp_pkg::WORD_W] != 2'b00)
            && (rip_next < stored_r)) begin
          ram_re      = 1'b1;
          ram_raddr   = rip_next[bdp_pkg::ADDR_W-1:0];
          rip_ptr_nxt = rip_next;
        end else begin
          finished_nxt = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = stored_r;
          if (resp_fin_r) begin
            out_word_nxt   = '0;
            out_status_nxt = (carry_r != '0) ? bdp_pkg::STAT_OVERFLOW : bdp_pkg::STAT_OK;
          end else begin
            out_word_nxt   = (resp_status_r == bdp_pkg::STAT_OK) ? ram_rdata : '0;
            out_status_nxt = resp_status_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stored_r    <= '0;
      partial_r   <= '0;
      filled_r    <= '0;
      carry_r     <= '0;
      finished_r  <= 1'b0;
      rip_ptr_r   <= '0;
      resp_fin_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stored_r    <= stored_nxt;
      partial_r   <= partial_nxt;
      filled_r    <= filled_nxt;
      carry_r     <= carry_nxt;
      finished_r  <= finished_nxt;
      rip_ptr_r   <= rip_ptr_nxt;
      resp_fin_r  <= resp_fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    resp_status_r <= resp_status_nxt;
    out_word_r    <= out_word_nxt;
    out_count_r   <= out_count_nxt;
    out_status_r  <= out_status_nxt;
  end

  bdp_ram #(
    .WIDTH (bdp_pkg::WORD_W),
    .DEPTH (bdp_pkg::MAX_WORDS)
  ) u_word_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bdp_pkg::OUT_W - bdp_pkg::OUT_BITS){1'b0}},
                       out_status_r, out_count_r, out_word_r};

`ifndef SYNTHESIS
  a_no_addr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("word store read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= bdp_pkg::MAX_CNT)
    else $error("word count beyond store depth");

  a_finished_clean: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> ((filled_r == '0) && (partial_r == '0)))
    else $error("partial word left after finish");

  a_ripple_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RIP) |-> (rip_ptr_r < stored_r))
    else $error("ripple pointer past stored words");
`endif

endmodule
